// ----- hw/rtl/sha256_stream_hasher_defines.svh -----
// ---------------------------------------------------------------------------
// SHA-256 stream hasher: assertion macros
// Concurrent check macros used by the hasher controller.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define SHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define SHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/shs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared codes, controller/datapath interface types and SHA-256 functions.
// ---------------------------------------------------------------------------
package shs_pkg;

  localparam logic [1:0] ACT_ABSORB        = 2'd0;
  localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] ACT_FINISH        = 2'd2;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] WORD_LAST  = 2'd3;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic       count_en;
    logic       vars_load;
    logic       round_en;
    logic [5:0] round_idx;
    logic       hash_add;
    logic       msg_init;
    logic       out_load;
    logic [1:0] out_index;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [31:0] init_hash(input logic [2:0] j);
    logic [31:0] v;
    unique case (j)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Absorb: one byte per cycle when not stalled; the byte that fills a 64-byte block stalls input
// while it is compressed: 64 rounds in one round unit, then the add into the chaining state.
// Finish: padding bytes, one or two compressions, then four digest words, one per cycle when
// the output is not stalled.
// Reset (synchronous, active high) loads the initial hash values, clears the byte count
// and empties the output register; buffer, schedule and round registers are not cleared.
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding and a four-word digest output.
// ---------------------------------------------------------------------------
module sha256_stream_hasher import shs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [63:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .action    (action),
    .sts       (sts),
    .cmd       (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .data_byte   (data_byte),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/shs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Byte buffer / schedule window, round unit, chaining state, byte count and
// the digest output register.
// ---------------------------------------------------------------------------
module shs_datapath import shs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  output dp_sts_t          sts,
  input  wire logic [7:0]  data_byte,
  output logic             dig_valid,
  input  wire logic        dig_stall,
  output logic [63:0]      digest_word,
  output logic [1:0]       word_index,
  output logic             last_word
);

  logic [511:0] window;
  logic [5:0]   fill;
  logic [63:0]  byte_count;
  logic [31:0]  hash_state [8];
  logic [31:0]  round_var [8];

  logic [63:0]  bit_len;
  logic [63:0]  len_shift;
  logic [7:0]   shift_byte;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2;

  assign bit_len   = {byte_count[60:0], 3'b000};
  assign len_shift = bit_len << {fill[2:0], 3'b000};

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_DATA: shift_byte = data_byte;
      BSEL_MARK: shift_byte = PAD_MARK;
      BSEL_ZERO: shift_byte = 8'h00;
      BSEL_LEN:  shift_byte = len_shift[63:56];
      default:   shift_byte = 8'h00;
    endcase
  end

  assign w0    = window[511:480];
  assign w1    = window[479:448];
  assign w9    = window[223:192];
  assign w14   = window[63:32];
  assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

  assign t1 = round_var[7] + big_sig1(round_var[4])
            + ((round_var[4] & round_var[5]) ^ (~round_var[4] & round_var[6]))
            + round_k(cmd.round_idx) + w0;
  assign t2 = big_sig0(round_var[0])
            + ((round_var[0] & round_var[1]) ^ (round_var[0] & round_var[2])
               ^ (round_var[1] & round_var[2]));

  assign sts.fill     = fill;
  assign sts.out_free = !dig_valid || !dig_stall;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      window <= {window[503:0], shift_byte};
    end else if (cmd.round_en) begin
      window <= {window[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vars_load) begin
      for (int j = 0; j < 8; j++) begin
        round_var[j] <= hash_state[j];
      end
    end else if (cmd.round_en) begin
      round_var[0] <= t1 + t2;
      round_var[1] <= round_var[0];
      round_var[2] <= round_var[1];
      round_var[3] <= round_var[2];
      round_var[4] <= round_var[3] + t1;
      round_var[5] <= round_var[4];
      round_var[6] <= round_var[5];
      round_var[7] <= round_var[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.msg_init) begin
      for (int j = 0; j < 8; j++) begin
        hash_state[j] <= init_hash(3'(j));
      end
      byte_count <= '0;
      fill       <= '0;
    end else begin
      if (cmd.hash_add) begin
        for (int j = 0; j < 8; j++) begin
          hash_state[j] <= hash_state[j] + round_var[j];
        end
      end else if (cmd.out_load) begin
        for (int j = 0; j < 6; j++) begin
          hash_state[j] <= hash_state[j + 2];
        end
      end
      if (cmd.count_en) begin
        byte_count <= byte_count + 64'd1;
      end
      if (cmd.shift_en) begin
        fill <= fill + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= 1'b0;
    end else if (cmd.out_load) begin
      dig_valid <= 1'b1;
    end else if (!dig_stall) begin
      dig_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digest_word <= {hash_state[0], hash_state[1]};
      word_index  <= cmd.out_index;
      last_word   <= (cmd.out_index == WORD_LAST);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/shs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences byte intake, padding, the 64 compression rounds and digest output.
// ---------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module shs_ctrl import shs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       msg_valid,
  output logic            msg_stall,
  input  wire logic [1:0] action,
  input  wire dp_sts_t    sts,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_UPDATE,
    S_PAD,
    S_OUT
  } state_t;

  state_t     state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [1:0] wcnt, wcnt_next;
  logic       fin, fin_next;
  logic       marker_done, marker_done_next;
  logic       extra_blk, extra_blk_next;
  logic       last_blk, last_blk_next;
  logic       len_zone;

  assign msg_stall = (state != S_IDLE);
  assign len_zone  = (sts.fill[5:3] == 3'b111);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    rnd_next         = rnd;
    wcnt_next        = wcnt;
    fin_next         = fin;
    marker_done_next = marker_done;
    extra_blk_next   = extra_blk;
    last_blk_next    = last_blk;
    unique case (state)
      S_IDLE: begin
        if (msg_valid) begin
          fin_next         = (action == ACT_ABSORB_FINISH) || (action == ACT_FINISH);
          marker_done_next = 1'b0;
          extra_blk_next   = 1'b0;
          last_blk_next    = 1'b0;
          if ((action == ACT_ABSORB) || (action == ACT_ABSORB_FINISH)) begin
            cmd.shift_en = 1'b1;
            cmd.byte_sel = BSEL_DATA;
            cmd.count_en = 1'b1;
            if (sts.fill == FILL_LAST) begin
              cmd.vars_load = 1'b1;
              rnd_next      = '0;
              state_next    = S_ROUND;
            end else if (action == ACT_ABSORB_FINISH) begin
              state_next = S_PAD;
            end
          end else if (action == ACT_FINISH) begin
            state_next = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round_en  = 1'b1;
        cmd.round_idx = rnd;
        rnd_next      = rnd + 6'd1;
        if (rnd == ROUND_LAST) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.hash_add = 1'b1;
        if (last_blk) begin
          wcnt_next  = '0;
          state_next = S_OUT;
        end else if (fin) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PAD: begin
        cmd.shift_en     = 1'b1;
        marker_done_next = 1'b1;
        if (!marker_done) begin
          cmd.byte_sel = BSEL_MARK;
          if (len_zone) begin
            extra_blk_next = 1'b1;
          end
        end else if (len_zone && !extra_blk) begin
          cmd.byte_sel = BSEL_LEN;
        end else begin
          cmd.byte_sel = BSEL_ZERO;
        end
        if (sts.fill == FILL_LAST) begin
          cmd.vars_load  = 1'b1;
          rnd_next       = '0;
          extra_blk_next = 1'b0;
          last_blk_next  = (cmd.byte_sel == BSEL_LEN);
          state_next     = S_ROUND;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_index = wcnt;
          wcnt_next     = wcnt + 2'd1;
          if (wcnt == WORD_LAST) begin
            cmd.msg_init = 1'b1;
            fin_next     = 1'b0;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rnd         <= '0;
      wcnt        <= '0;
      fin         <= 1'b0;
      marker_done <= 1'b0;
      extra_blk   <= 1'b0;
      last_blk    <= 1'b0;
    end else begin
      state       <= state_next;
      rnd         <= rnd_next;
      wcnt        <= wcnt_next;
      fin         <= fin_next;
      marker_done <= marker_done_next;
      extra_blk   <= extra_blk_next;
      last_blk    <= last_blk_next;
    end
  end

  `SHS_ASSERT_NEXT(a_round_start, clk, rst, cmd.vars_load, (state == S_ROUND) && (rnd == '0), "compression did not start at round zero")
  `SHS_ASSERT_IMP(a_update_after_rounds, clk, rst, state == S_UPDATE, ($past(state) == S_ROUND) && ($past(rnd) == ROUND_LAST), "state update without a full round pass")
  `SHS_ASSERT_IMP(a_compress_on_full, clk, rst, cmd.vars_load, sts.fill == FILL_LAST, "compression started on a partial block")
  `SHS_ASSERT_IMP(a_out_on_free, clk, rst, cmd.out_load, sts.out_free, "digest word loaded over a pending transaction")

endmodule
`default_nettype wire
